// ===== src/blpc_pkg.sv =====
// Shared types and constants for the button lockout pulse controller.
package blpc_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int ELAPSED_W   = CFG_DATA_W + 1;
    localparam int TICK_W_DEF  = 16;
    localparam int NUM_PULSE   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE   = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] LOCKOUT_RST = CFG_DATA_W'(110);
    localparam logic [CFG_DATA_W-1:0] PULSE_RST   = CFG_DATA_W'(100);

    localparam logic [1:0] POS_RX_A = 2'd0;
    localparam logic [1:0] POS_TX   = 2'd1;
    localparam logic [1:0] POS_RX_B = 2'd2;

    localparam logic [1:0] MODE_RX_A = 2'd0;
    localparam logic [1:0] MODE_RX_B = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] lockout_ticks;
        logic [CFG_DATA_W-1:0] pulse_ticks;
    } t_cfg;

endpackage

// ===== src/blpc_if.sv =====
// Handshake channel interfaces: input ticks, results and configuration writes.
interface blpc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] switch_position;
    logic       button_a;
    logic       button_b;

    modport source (output valid, switch_position, button_a, button_b, input ready);
    modport sink   (input valid, switch_position, button_a, button_b, output ready);
endinterface

interface blpc_out_if;
    logic       valid;
    logic       ready;
    logic       video_source_high;
    logic       pulse_rx_a;
    logic       pulse_rx_b;
    logic       pulse_tx;
    logic       platform_event;
    logic [1:0] current_mode;

    modport source (output valid, video_source_high, pulse_rx_a, pulse_rx_b, pulse_tx,
                    platform_event, current_mode, input ready);
    modport sink   (input valid, video_source_high, pulse_rx_a, pulse_rx_b, pulse_tx,
                    platform_event, current_mode, output ready);
endinterface

interface blpc_cfg_if;
    import blpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/button_lockout_pulse_controller.sv =====
// Top level of the button lockout pulse controller.
// Takes one tick transaction per clock while the result side keeps taking, and presents one
// result transaction per tick; the input register loads at the accepting edge and the result
// register once the result slot is free, so the sustained rate is one tick per cycle while
// results are taken. A button press is taken only when
// more than lockout_ticks ticks have passed since the last one taken on that button;
// button A then starts or restarts a pulse of pulse_ticks ticks on the output of the mode
// in force after this tick's switch handling, and button B gives a one-tick platform event.
// Configuration registers: index 0 lockout_ticks, index 1 pulse_ticks; write only while
// no tick is in flight.
module button_lockout_pulse_controller #(
    parameter int TICK_WIDTH = blpc_pkg::TICK_W_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpc_cfg_if.sink    i_cfg,
    blpc_in_if.sink     i_in,
    blpc_out_if.source  o_out
);
    import blpc_pkg::*;

    t_cfg cfg;

    blpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    blpc_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== src/blpc_cfg.sv =====
// Configuration register file for lockout and pulse length.
module blpc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    blpc_cfg_if.sink      i_cfg,
    output blpc_pkg::t_cfg o_cfg
);
    import blpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LOCKOUT: n_cfg.lockout_ticks = i_cfg.data;
                REG_PULSE:   n_cfg.pulse_ticks   = i_cfg.data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_ticks <= LOCKOUT_RST;
            r_cfg.pulse_ticks   <= PULSE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/blpc_core.sv =====
// Tick datapath: input register, switch/button/pulse state and result register.
module blpc_core #(
    parameter int TICK_WIDTH = blpc_pkg::TICK_W_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  blpc_pkg::t_cfg i_cfg,
    blpc_in_if.sink        i_in,
    blpc_out_if.source     o_out
);
    import blpc_pkg::*;

    // input register
    logic       r_in_valid;
    logic [1:0] r_pos;
    logic       r_ba;
    logic       r_bb;

    // tick state
    logic                 r_seen;
    logic [1:0]           r_last_pos;
    logic [1:0]           r_mode;
    logic                 r_src;
    logic                 r_prev_a;
    logic                 r_prev_b;
    logic [ELAPSED_W-1:0] r_elapsed_a;
    logic [ELAPSED_W-1:0] r_elapsed_b;
    logic [TICK_WIDTH-1:0] r_pulse [NUM_PULSE];

    // result register
    logic       r_out_valid;
    logic       r_o_src;
    logic [NUM_PULSE-1:0] r_o_pulse;
    logic       r_o_event;
    logic [1:0] r_o_mode;

    logic                  out_free;
    logic                  fire;
    logic                  pos_chg;
    logic [1:0]            n_mode;
    logic                  n_src;
    logic                  press_a;
    logic                  press_b;
    logic [ELAPSED_W-1:0]  lockout_ext;
    logic [ELAPSED_W-1:0]  mid_a;
    logic [ELAPSED_W-1:0]  mid_b;
    logic [ELAPSED_W-1:0]  n_elapsed_a;
    logic [ELAPSED_W-1:0]  n_elapsed_b;
    logic [TICK_WIDTH+CFG_DATA_W-1:0] pulse_ext;
    logic [TICK_WIDTH-1:0] pulse_len;
    logic [TICK_WIDTH-1:0] pulse_mid [NUM_PULSE];
    logic [TICK_WIDTH-1:0] n_pulse   [NUM_PULSE];
    logic [NUM_PULSE-1:0]  pulse_on;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign lockout_ext = {1'b0, i_cfg.lockout_ticks};
    assign pulse_ext   = {{TICK_WIDTH{1'b0}}, i_cfg.pulse_ticks};
    assign pulse_len   = pulse_ext[TICK_WIDTH-1:0];

    always_comb begin
        pos_chg = !r_seen || (r_pos != r_last_pos);
        n_mode  = r_mode;
        n_src   = r_src;
        if (pos_chg) begin
            case (r_pos)
                POS_RX_A: begin
                    n_mode = MODE_RX_A;
                    n_src  = 1'b1;
                end
                POS_TX: begin
                    n_mode = MODE_TX;
                end
                POS_RX_B: begin
                    n_mode = MODE_RX_B;
                    n_src  = 1'b0;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end

        press_a = r_ba && !r_prev_a && (r_elapsed_a > lockout_ext);
        press_b = r_bb && !r_prev_b && (r_elapsed_b > lockout_ext);

        for (int i = 0; i < NUM_PULSE; i++) begin
            if (press_a && (n_mode == 2'(i))) begin
                pulse_mid[i] = pulse_len;
            end else begin
                pulse_mid[i] = r_pulse[i];
            end
            pulse_on[i] = (pulse_mid[i] != '0);
            n_pulse[i]  = pulse_on[i] ? pulse_mid[i] - TICK_WIDTH'(1) : pulse_mid[i];
        end

        mid_a = press_a ? '0 : r_elapsed_a;
        mid_b = press_b ? '0 : r_elapsed_b;
        n_elapsed_a = (mid_a <= lockout_ext) ? mid_a + ELAPSED_W'(1) : mid_a;
        n_elapsed_b = (mid_b <= lockout_ext) ? mid_b + ELAPSED_W'(1) : mid_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
            r_last_pos  <= POS_RX_A;
            r_mode      <= MODE_RX_A;
            r_src       <= 1'b0;
            r_prev_a    <= 1'b0;
            r_prev_b    <= 1'b0;
            r_elapsed_a <= '0;
            r_elapsed_b <= '0;
            for (int i = 0; i < NUM_PULSE; i++) begin
                r_pulse[i] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_seen      <= 1'b1;
                r_last_pos  <= r_pos;
                r_mode      <= n_mode;
                r_src       <= n_src;
                r_prev_a    <= r_ba;
                r_prev_b    <= r_bb;
                r_elapsed_a <= n_elapsed_a;
                r_elapsed_b <= n_elapsed_b;
                for (int i = 0; i < NUM_PULSE; i++) begin
                    r_pulse[i] <= n_pulse[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pos <= i_in.switch_position;
            r_ba  <= i_in.button_a;
            r_bb  <= i_in.button_b;
        end
        if (fire) begin
            r_o_src   <= n_src;
            r_o_pulse <= pulse_on;
            r_o_event <= press_b;
            r_o_mode  <= n_mode;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.video_source_high = r_o_src;
    assign o_out.pulse_rx_a        = r_o_pulse[MODE_RX_A];
    assign o_out.pulse_rx_b        = r_o_pulse[MODE_RX_B];
    assign o_out.pulse_tx          = r_o_pulse[MODE_TX];
    assign o_out.platform_event    = r_o_event;
    assign o_out.current_mode      = r_o_mode;

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_RX_A || r_mode == MODE_RX_B || r_mode == MODE_TX)
        else $error("mode register holds an unused code");

    a_press_a_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && press_a |=> r_elapsed_a == ELAPSED_W'(1))
        else $error("accepted press did not restart lockout");

    a_event_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && press_b |=> r_prev_b && r_o_event && r_out_valid)
        else $error("platform event without a recorded button edge");

    a_src_rx_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && pos_chg && r_pos == POS_RX_A |=> r_src && r_mode == MODE_RX_A)
        else $error("position for mode A did not raise the source pin");

    a_no_fire_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !fire)
        else $error("result overwritten while stalled");

endmodule
